/* sv/hbp_pkg.sv */
// Package for the hybrid branch predictor: defaults, codes and counter helpers.
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

  localparam int MaxBimodalBitsDef = 14;
  localparam int MaxGshareBitsDef  = 14;
  localparam int MaxChooserBitsDef = 14;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE         = 3'd0,
    REG_BIMODAL_BITS = 3'd1,
    REG_GSHARE_BITS  = 3'd2,
    REG_HISTORY_BITS = 3'd3,
    REG_CHOOSER_BITS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2
  } pred_mode_t;

  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CHO_FAVOR_BIM  = 2'd1;
  localparam logic [1:0] CTR_MAX        = 2'd3;
  localparam logic [1:0] CTR_MIN        = 2'd0;

  localparam logic [CfgDataW-1:0] RST_BIMODAL_BITS = 4'd14;
  localparam logic [CfgDataW-1:0] RST_GSHARE_BITS  = 4'd14;
  localparam logic [CfgDataW-1:0] RST_HISTORY_BITS = 4'd8;
  localparam logic [CfgDataW-1:0] RST_CHOOSER_BITS = 4'd14;

  localparam int InDataW  = 40;
  localparam int OutDataW = 72;

  // 2-bit saturating counter step
  function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/hybrid_branch_predictor.sv */
// Hybrid bimodal / gshare branch predictor with chooser table, top level.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   branch_address, taken
// m_*       out  m_tvalid/m_tready   predicted_taken, mispredicted, used_gshare, totals
// cfg_*     in   cfg_we              cfg_index selects register, cfg_data value
//
// One branch per cycle sustained while not clearing and m_tready is high. Indices
// are formed and the three counter memories read at accept, then predict, train and
// write back. A write followed by a read of the same entry is covered by a forwarding
// register. After rst a clearing pass over all 2**max(MAX_*_BITS) indices (16384 by
// default) loads the counter tables; s_tready stays low meanwhile. A stalled m_tready
// holds one result in the output register and one in flight before s_tready drops.
module hybrid_branch_predictor
  import hbp_pkg::*;
#(
  parameter int MAX_BIMODAL_BITS = MaxBimodalBitsDef,
  parameter int MAX_GSHARE_BITS  = MaxGshareBitsDef,
  parameter int MAX_CHOOSER_BITS = MaxChooserBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // [31:0] branch_address, [32] taken, [39:33] zero
  input  wire logic [InDataW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [0] predicted_taken, [1] mispredicted, [2] used_gshare,
  // [34:3] branch_total, [66:35] mispredict_total, [71:67] zero
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int BW  = MAX_BIMODAL_BITS;
  localparam int GW  = MAX_GSHARE_BITS;
  localparam int CW  = MAX_CHOOSER_BITS;
  localparam int BBW = $clog2(BW + 1);
  localparam int GBW = $clog2(GW + 1);
  localparam int CBW = $clog2(CW + 1);
  localparam int CLRW = (BW > GW) ? ((BW > CW) ? BW : CW) : ((GW > CW) ? GW : CW);

  // configuration registers
  logic [1:0]          mode_reg;
  logic [CfgDataW-1:0] bim_bits_reg, gsh_bits_reg, hist_bits_reg, cho_bits_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_HYBRID;
      bim_bits_reg  <= RST_BIMODAL_BITS;
      gsh_bits_reg  <= RST_GSHARE_BITS;
      hist_bits_reg <= RST_HISTORY_BITS;
      cho_bits_reg  <= RST_CHOOSER_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         mode_reg      <= cfg_data[1:0];
        REG_BIMODAL_BITS: bim_bits_reg  <= cfg_data;
        REG_GSHARE_BITS:  gsh_bits_reg  <= cfg_data;
        REG_HISTORY_BITS: hist_bits_reg <= cfg_data;
        REG_CHOOSER_BITS: cho_bits_reg  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic mode_bim, mode_gsh, mode_hyb;
  assign mode_bim = (mode_reg == MODE_BIMODAL);
  assign mode_gsh = (mode_reg == MODE_GSHARE);
  assign mode_hyb = !mode_bim && !mode_gsh;

  // effective widths
  logic [BBW-1:0] bb;
  logic [GBW-1:0] gb, hb, diff, hb_m1;
  logic [CBW-1:0] cb;

  always_comb begin
    if (bim_bits_reg == '0) bb = BBW'(1);
    else if (int'(bim_bits_reg) > BW) bb = BBW'(BW);
    else bb = BBW'(bim_bits_reg);

    if (gsh_bits_reg == '0) gb = GBW'(1);
    else if (int'(gsh_bits_reg) > GW) gb = GBW'(GW);
    else gb = GBW'(gsh_bits_reg);

    if (hist_bits_reg == '0) hb = GBW'(1);
    else if (int'(hist_bits_reg) > int'(gb)) hb = gb;
    else hb = GBW'(hist_bits_reg);

    if (cho_bits_reg == '0) cb = CBW'(1);
    else if (int'(cho_bits_reg) > CW) cb = CBW'(CW);
    else cb = CBW'(cho_bits_reg);

    diff  = gb - hb;
    hb_m1 = hb - GBW'(1);
  end

  // input fields
  logic [31:0] branch_address;
  logic        taken;
  logic [29:0] src;
  assign branch_address = s_tdata[31:0];
  assign taken          = s_tdata[32];
  assign src            = branch_address[31:2];

  logic [BW-1:0] bmask;
  logic [GW-1:0] gmask, hmask;
  logic [CW-1:0] cmask;

  always_comb begin
    for (int i = 0; i < BW; i++) bmask[i] = (i < int'(bb));
    for (int i = 0; i < GW; i++) gmask[i] = (i < int'(gb));
    for (int i = 0; i < GW; i++) hmask[i] = (i < int'(hb));
    for (int i = 0; i < CW; i++) cmask[i] = (i < int'(cb));
  end

  logic [GW-1:0] ghist;
  logic [BW-1:0] bi_in;
  logic [GW-1:0] gi_in;
  logic [CW-1:0] ci_in;

  assign bi_in = src[BW-1:0] & bmask;
  assign gi_in = (src[GW-1:0] & gmask) ^ ((ghist & hmask) << diff);
  assign ci_in = src[CW-1:0] & cmask;

  // clearing pass
  logic            clearing;
  logic [CLRW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + CLRW'(1);
      if (clr_idx == {CLRW{1'b1}}) clearing <= 1'b0;
    end
  end

  // pipeline control
  logic s1_valid, s1_adv, accept, out_valid;
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // history is updated at accept: it depends only on the outcome and the config
  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
    end else if (accept && !mode_bim) begin
      ghist <= (ghist >> 1) | (GW'(taken) << hb_m1);
    end
  end

  logic [BW-1:0] s1_bi;
  logic [GW-1:0] s1_gi;
  logic [CW-1:0] s1_ci;
  logic          s1_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bi    <= bi_in;
      s1_gi    <= gi_in;
      s1_ci    <= ci_in;
      s1_taken <= taken;
    end
  end

  // counter memories
  logic [1:0] bim_mem [2**BW];
  logic [1:0] gsh_mem [2**GW];
  logic [1:0] cho_mem [2**CW];
  logic [1:0] bim_rd, gsh_rd, cho_rd;
  logic       bim_we, gsh_we, cho_we;
  logic [1:0] bim_wd, gsh_wd, cho_wd;

  always_ff @(posedge clk) begin
    if (clearing) bim_mem[clr_idx[BW-1:0]] <= CTR_WEAK_TAKEN;
    else if (bim_we) bim_mem[s1_bi] <= bim_wd;
    if (accept) bim_rd <= bim_mem[bi_in];
  end

  always_ff @(posedge clk) begin
    if (clearing) gsh_mem[clr_idx[GW-1:0]] <= CTR_WEAK_TAKEN;
    else if (gsh_we) gsh_mem[s1_gi] <= gsh_wd;
    if (accept) gsh_rd <= gsh_mem[gi_in];
  end

  always_ff @(posedge clk) begin
    if (clearing) cho_mem[clr_idx[CW-1:0]] <= CHO_FAVOR_BIM;
    else if (cho_we) cho_mem[s1_ci] <= cho_wd;
    if (accept) cho_rd <= cho_mem[ci_in];
  end

  // last write per table, covers a read taken at the same edge as that write
  logic          bfwd_vld, gfwd_vld, cfwd_vld;
  logic [BW-1:0] bfwd_idx;
  logic [GW-1:0] gfwd_idx;
  logic [CW-1:0] cfwd_idx;
  logic [1:0]    bfwd_data, gfwd_data, cfwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bfwd_vld <= 1'b0;
      gfwd_vld <= 1'b0;
      cfwd_vld <= 1'b0;
    end else begin
      if (bim_we) bfwd_vld <= 1'b1;
      if (gsh_we) gfwd_vld <= 1'b1;
      if (cho_we) cfwd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bim_we) begin
      bfwd_idx  <= s1_bi;
      bfwd_data <= bim_wd;
    end
    if (gsh_we) begin
      gfwd_idx  <= s1_gi;
      gfwd_data <= gsh_wd;
    end
    if (cho_we) begin
      cfwd_idx  <= s1_ci;
      cfwd_data <= cho_wd;
    end
  end

  // predict and train
  logic [1:0] bcnt, gcnt, ccnt;
  logic       use_g, bpred, gpred, pred, miss, gok, bok;

  always_comb begin
    bcnt  = (bfwd_vld && bfwd_idx == s1_bi) ? bfwd_data : bim_rd;
    gcnt  = (gfwd_vld && gfwd_idx == s1_gi) ? gfwd_data : gsh_rd;
    ccnt  = (cfwd_vld && cfwd_idx == s1_ci) ? cfwd_data : cho_rd;
    bpred = bcnt[1];
    gpred = gcnt[1];
    use_g = mode_gsh || (mode_hyb && ccnt[1]);
    pred  = use_g ? gpred : bpred;
    miss  = pred ^ s1_taken;
    gok   = (gpred == s1_taken);
    bok   = (bpred == s1_taken);

    bim_we = s1_adv && !use_g;
    gsh_we = s1_adv && use_g;
    cho_we = s1_adv && mode_hyb && (gok != bok);
    bim_wd = sat_step(bcnt, s1_taken);
    gsh_wd = sat_step(gcnt, s1_taken);
    cho_wd = sat_step(ccnt, gok);
  end

  // output register; the running totals double as payload
  logic        out_pred, out_miss, out_useg;
  logic [31:0] branch_count, mispredict_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      branch_count     <= '0;
      mispredict_count <= '0;
    end else begin
      if (s1_adv) begin
        out_valid        <= 1'b1;
        branch_count     <= branch_count + 32'd1;
        mispredict_count <= mispredict_count + {31'd0, miss};
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred <= pred;
      out_miss <= miss;
      out_useg <= use_g;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, mispredict_count, branch_count, out_useg, out_miss, out_pred};

endmodule
`default_nettype wire
